@@ rtl/blwd_pkg.sv @@
// shared types and constants of the backlight level keeper with thermal derate
// used by blwd_divider, blwd_datapath, blwd_ctrl and the top level
package blwd_pkg;

  // field widths
  localparam int LEVEL_BITS = 14;
  localparam int FS_BITS    = 14;
  localparam int TEMP_BITS  = 8;
  localparam int PCT_BITS   = 7;
  localparam int PREQ_BITS  = 8;
  localparam int RB_BITS    = 16;
  localparam int MODE_BITS  = 3;
  localparam int DIGIT_BITS = 6;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // shared divider: numerator covers full_scale * 25500, divisor covers 2 * full_scale
  localparam int NUM_BITS = 29;
  localparam int DEN_BITS = 15;
  localparam int CNT_BITS = 5;

  // reciprocal divides by constants: full_scale / 10 and full_scale * percent / 100
  localparam logic [15:0] RECIP_TEN           = 16'd52429;
  localparam int          RECIP_TEN_SHIFT     = 19;
  localparam int          SET_NUM_BITS        = 21;
  localparam logic [21:0] RECIP_HUNDRED       = 22'd2684355;
  localparam int          RECIP_HUNDRED_SHIFT = 28;

  // reset values
  localparam logic [FS_BITS-1:0]    FS_RESET    = 14'd9830;
  localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 14'd9830;
  localparam logic [TEMP_BITS-1:0]  START_RESET = 8'd65;
  localparam logic [TEMP_BITS-1:0]  END_RESET   = 8'd85;
  localparam logic [PCT_BITS-1:0]   FLOOR_RESET = 7'd10;

  localparam logic [PCT_BITS-1:0]   PCT_FULL   = 7'd100;
  localparam logic [DIGIT_BITS-1:0] ASCII_ZERO = 6'h30;

  // event modes
  localparam logic [MODE_BITS-1:0] MODE_DOWN     = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_UP       = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_SET      = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_TEMP     = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_READBACK = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_FULL_SCALE  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_START_TEMP  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_END_TEMP    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FLOOR_PCT   = 3'd3;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_STEP_DIV,
    OP_STEP_APPLY,
    OP_SET_MUL,
    OP_SET_APPLY,
    OP_CAP_INNER,
    OP_CAP_MUL,
    OP_CAP_DIV,
    OP_CAP_APPLY,
    OP_PCT_DIV,
    OP_PCT_APPLY,
    OP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic                 preq_ok;
    logic                 temp_hot;
    logic                 div_done;
  } dp_status_t;

endpackage

@@ rtl/blwd_divider.sv @@
// iterative restoring divider, one quotient bit per cycle
// depends on blwd_pkg for operand widths
module blwd_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [blwd_pkg::NUM_BITS-1:0] num,
  input  logic [blwd_pkg::DEN_BITS-1:0] den,
  output logic [blwd_pkg::NUM_BITS-1:0] quot,
  output logic                          done
);

  logic                          busy;
  logic [blwd_pkg::CNT_BITS-1:0] cnt;
  logic [blwd_pkg::DEN_BITS-1:0] rem;
  logic [blwd_pkg::DEN_BITS-1:0] den_r;
  logic [blwd_pkg::NUM_BITS-1:0] work;
  logic [blwd_pkg::DEN_BITS:0]   trial;
  logic [blwd_pkg::DEN_BITS:0]   diff;
  logic                          ge;

  // one shift and trial subtract
  always_comb begin
    trial = {rem, work[blwd_pkg::NUM_BITS-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= blwd_pkg::CNT_BITS'(blwd_pkg::NUM_BITS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      work  <= num;
      den_r <= den;
    end else if (busy) begin
      rem  <= ge ? diff[blwd_pkg::DEN_BITS-1:0] : trial[blwd_pkg::DEN_BITS-1:0];
      work <= {work[blwd_pkg::NUM_BITS-2:0], ge};
    end
  end

  assign quot = work;

endmodule

@@ rtl/blwd_datapath.sv @@
// datapath: configuration, level register, operand preparation, output register
// depends on blwd_pkg and instantiates blwd_divider
module blwd_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  blwd_pkg::dp_cmd_t                  cmd,
  output blwd_pkg::dp_status_t               status,
  input  logic                               cfg_we,
  input  logic [blwd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [blwd_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic [blwd_pkg::MODE_BITS-1:0]     mode,
  input  logic [blwd_pkg::PREQ_BITS-1:0]     percent_request,
  input  logic [blwd_pkg::TEMP_BITS-1:0]     temperature,
  input  logic [blwd_pkg::RB_BITS-1:0]       readback_value,
  output logic [blwd_pkg::LEVEL_BITS-1:0]    level,
  output logic                               write_request,
  output logic [blwd_pkg::PCT_BITS-1:0]      shown_percent,
  output logic [blwd_pkg::DIGIT_BITS-1:0]    digit_hundreds,
  output logic [blwd_pkg::DIGIT_BITS-1:0]    digit_tens,
  output logic [blwd_pkg::DIGIT_BITS-1:0]    digit_units
);

  // configuration registers
  logic [blwd_pkg::FS_BITS-1:0]   full_scale;
  logic [blwd_pkg::TEMP_BITS-1:0] start_temp;
  logic [blwd_pkg::TEMP_BITS-1:0] end_temp;
  logic [blwd_pkg::PCT_BITS-1:0]  floor_pct;

  // state and item registers
  logic [blwd_pkg::LEVEL_BITS-1:0] cur_level;
  logic [blwd_pkg::MODE_BITS-1:0]  mode_r;
  logic [blwd_pkg::PREQ_BITS-1:0]  preq_r;
  logic [blwd_pkg::TEMP_BITS-1:0]  temp_r;
  logic [blwd_pkg::RB_BITS-1:0]    rb_r;
  logic                            wr_r;
  logic [blwd_pkg::LEVEL_BITS-1:0] step;
  logic [blwd_pkg::DEN_BITS-1:0]   inner;
  logic [blwd_pkg::DEN_BITS-1:0]   cap_den;
  logic [blwd_pkg::NUM_BITS-1:0]   prod;
  logic [blwd_pkg::PCT_BITS-1:0]   pct;

  // divider hookup
  logic                          div_start;
  logic [blwd_pkg::NUM_BITS-1:0] div_num;
  logic [blwd_pkg::DEN_BITS-1:0] div_den;
  logic [blwd_pkg::NUM_BITS-1:0] quot;
  logic                          div_done;

  // combinational helpers
  logic [blwd_pkg::PCT_BITS-1:0]   floor_c;
  logic                            linear;
  logic [blwd_pkg::TEMP_BITS-1:0]  span;
  logic [blwd_pkg::TEMP_BITS-1:0]  to_end;
  logic [blwd_pkg::TEMP_BITS-1:0]  from_start;
  logic [blwd_pkg::DEN_BITS-1:0]   inner_next;
  logic [blwd_pkg::DEN_BITS-1:0]   cap_den_next;
  logic [32:0]                     step_prod;
  logic [41:0]                     set_prod;
  logic [blwd_pkg::LEVEL_BITS-1:0] set_level;
  logic [blwd_pkg::LEVEL_BITS:0]   up_sum;
  logic [blwd_pkg::RB_BITS-1:0]    pct_src;
  logic [23:0]                     pct_num;
  logic [blwd_pkg::PCT_BITS-1:0]   pct_next;
  logic [blwd_pkg::PCT_BITS-1:0]   low_two;
  logic [14:0]                     tens_prod;
  logic [3:0]                      tens;
  logic [3:0]                      units;
  logic                            wr_next;

  blwd_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (quot),
    .done  (div_done)
  );

  // cap interpolation terms
  always_comb begin
    floor_c    = (floor_pct > blwd_pkg::PCT_FULL) ? blwd_pkg::PCT_FULL : floor_pct;
    linear     = (end_temp > start_temp) && (temp_r <= end_temp);
    span       = end_temp - start_temp;
    to_end     = end_temp - temp_r;
    from_start = temp_r - start_temp;
    if (linear) begin
      inner_next   = blwd_pkg::DEN_BITS'(7'd100 * to_end)
                   + blwd_pkg::DEN_BITS'(floor_c * from_start);
      cap_den_next = blwd_pkg::DEN_BITS'(7'd100 * span);
    end else begin
      inner_next   = blwd_pkg::DEN_BITS'(floor_c);
      cap_den_next = blwd_pkg::DEN_BITS'(7'd100);
    end
  end

  // step, set level, percent numerator, digit split
  always_comb begin
    // divide by ten and by one hundred through reciprocal multiplies, exact over range
    step_prod = 33'(full_scale) * 33'(blwd_pkg::RECIP_TEN);
    set_prod  = 42'(prod[blwd_pkg::SET_NUM_BITS-1:0]) * 42'(blwd_pkg::RECIP_HUNDRED);
    set_level = set_prod[blwd_pkg::RECIP_HUNDRED_SHIFT +: blwd_pkg::LEVEL_BITS];
    up_sum   = {1'b0, cur_level} + {1'b0, step};
    pct_src  = (mode_r == blwd_pkg::MODE_READBACK) ? rb_r
             : blwd_pkg::RB_BITS'(cur_level);
    // 200 * v as 128v + 64v + 8v, plus full scale for rounding
    pct_num  = {1'b0, pct_src, 7'b0} + {2'b0, pct_src, 6'b0} + {5'b0, pct_src, 3'b0}
             + 24'(full_scale);
    if (full_scale == '0) begin
      pct_next = '0;
    end else if (quot > blwd_pkg::NUM_BITS'(blwd_pkg::PCT_FULL)) begin
      pct_next = blwd_pkg::PCT_FULL;
    end else begin
      pct_next = quot[blwd_pkg::PCT_BITS-1:0];
    end
    low_two   = (pct == blwd_pkg::PCT_FULL) ? '0 : pct;
    // divide by ten through reciprocal, exact below 180
    tens_prod = low_two * 8'd205;
    tens      = tens_prod[14:11];
    units     = 4'(low_two - 7'(tens * 4'd10));
    wr_next   = (mode == blwd_pkg::MODE_DOWN) || (mode == blwd_pkg::MODE_UP)
             || ((mode == blwd_pkg::MODE_TEMP) && (temperature >= start_temp));
  end

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (cmd.op)
      blwd_pkg::OP_CAP_DIV: begin
        div_start = 1'b1;
        div_num   = prod;
        div_den   = cap_den;
      end
      blwd_pkg::OP_PCT_DIV: begin
        div_start = 1'b1;
        div_num   = blwd_pkg::NUM_BITS'(pct_num);
        div_den   = {full_scale, 1'b0};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // configuration and level register
  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= blwd_pkg::FS_RESET;
      start_temp <= blwd_pkg::START_RESET;
      end_temp   <= blwd_pkg::END_RESET;
      floor_pct  <= blwd_pkg::FLOOR_RESET;
      cur_level  <= blwd_pkg::LEVEL_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          blwd_pkg::CFG_FULL_SCALE: full_scale <= cfg_data[blwd_pkg::FS_BITS-1:0];
          blwd_pkg::CFG_START_TEMP: start_temp <= cfg_data[blwd_pkg::TEMP_BITS-1:0];
          blwd_pkg::CFG_END_TEMP:   end_temp   <= cfg_data[blwd_pkg::TEMP_BITS-1:0];
          blwd_pkg::CFG_FLOOR_PCT:  floor_pct  <= cfg_data[blwd_pkg::PCT_BITS-1:0];
          default: begin
          end
        endcase
      end
      unique case (cmd.op)
        blwd_pkg::OP_STEP_APPLY: begin
          if (mode_r == blwd_pkg::MODE_DOWN) begin
            if (cur_level == '0) begin
              cur_level <= full_scale;
            end else if (cur_level < step) begin
              cur_level <= '0;
            end else begin
              cur_level <= cur_level - step;
            end
          end else begin
            if (cur_level >= full_scale) begin
              cur_level <= '0;
            end else if (up_sum >= {1'b0, full_scale}) begin
              cur_level <= full_scale;
            end else begin
              cur_level <= up_sum[blwd_pkg::LEVEL_BITS-1:0];
            end
          end
        end
        blwd_pkg::OP_SET_APPLY: begin
          cur_level <= set_level;
        end
        blwd_pkg::OP_CAP_APPLY: begin
          if (blwd_pkg::NUM_BITS'(cur_level) > quot) begin
            cur_level <= quot[blwd_pkg::LEVEL_BITS-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // item latch, working registers and output register
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      blwd_pkg::OP_LOAD: begin
        mode_r <= mode;
        preq_r <= percent_request;
        temp_r <= temperature;
        rb_r   <= readback_value;
        wr_r   <= wr_next;
      end
      blwd_pkg::OP_STEP_DIV: begin
        step <= step_prod[blwd_pkg::RECIP_TEN_SHIFT +: blwd_pkg::LEVEL_BITS];
      end
      blwd_pkg::OP_SET_MUL: begin
        prod <= blwd_pkg::NUM_BITS'(full_scale * preq_r);
      end
      blwd_pkg::OP_CAP_INNER: begin
        inner   <= inner_next;
        cap_den <= cap_den_next;
      end
      blwd_pkg::OP_CAP_MUL: begin
        prod <= blwd_pkg::NUM_BITS'(full_scale * inner);
      end
      blwd_pkg::OP_PCT_APPLY: begin
        pct <= pct_next;
      end
      blwd_pkg::OP_OUT_LOAD: begin
        level          <= cur_level;
        write_request  <= wr_r;
        shown_percent  <= pct;
        digit_hundreds <= (pct == blwd_pkg::PCT_FULL) ? blwd_pkg::ASCII_ZERO + 6'd1
                        : blwd_pkg::ASCII_ZERO;
        digit_tens     <= blwd_pkg::ASCII_ZERO + 6'(tens);
        digit_units    <= blwd_pkg::ASCII_ZERO + 6'(units);
      end
      default: begin
      end
    endcase
  end

  // status back to the controller
  always_comb begin
    status.mode     = mode_r;
    status.preq_ok  = (preq_r <= 8'd100);
    status.temp_hot = (temp_r >= start_temp);
    status.div_done = div_done;
  end

endmodule

@@ rtl/blwd_ctrl.sv @@
// controller: sequences one item through the datapath and runs both handshakes
// depends on blwd_pkg for command and status types
module blwd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  blwd_pkg::dp_status_t status,
  output blwd_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_STEP_APPLY,
    S_SET_APPLY,
    S_CAP_MUL,
    S_CAP_DIV,
    S_CAP_WAIT,
    S_PCT_START,
    S_PCT_WAIT,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // next state and datapath command
  always_comb begin
    state_next = state;
    cmd.op     = blwd_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = blwd_pkg::OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if ((status.mode == blwd_pkg::MODE_DOWN) || (status.mode == blwd_pkg::MODE_UP)) begin
          cmd.op     = blwd_pkg::OP_STEP_DIV;
          state_next = S_STEP_APPLY;
        end else if ((status.mode == blwd_pkg::MODE_SET) && status.preq_ok) begin
          cmd.op     = blwd_pkg::OP_SET_MUL;
          state_next = S_SET_APPLY;
        end else if ((status.mode == blwd_pkg::MODE_TEMP) && status.temp_hot) begin
          cmd.op     = blwd_pkg::OP_CAP_INNER;
          state_next = S_CAP_MUL;
        end else begin
          cmd.op     = blwd_pkg::OP_PCT_DIV;
          state_next = S_PCT_WAIT;
        end
      end
      S_STEP_APPLY: begin
        cmd.op     = blwd_pkg::OP_STEP_APPLY;
        state_next = S_PCT_START;
      end
      S_SET_APPLY: begin
        cmd.op     = blwd_pkg::OP_SET_APPLY;
        state_next = S_PCT_START;
      end
      S_CAP_MUL: begin
        cmd.op     = blwd_pkg::OP_CAP_MUL;
        state_next = S_CAP_DIV;
      end
      S_CAP_DIV: begin
        cmd.op     = blwd_pkg::OP_CAP_DIV;
        state_next = S_CAP_WAIT;
      end
      S_CAP_WAIT: begin
        if (status.div_done) begin
          cmd.op     = blwd_pkg::OP_CAP_APPLY;
          state_next = S_PCT_START;
        end
      end
      S_PCT_START: begin
        cmd.op     = blwd_pkg::OP_PCT_DIV;
        state_next = S_PCT_WAIT;
      end
      S_PCT_WAIT: begin
        if (status.div_done) begin
          cmd.op     = blwd_pkg::OP_PCT_APPLY;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.op     = blwd_pkg::OP_OUT_LOAD;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/backlight_level_with_thermal_derate.sv @@
// Backlight level keeper with thermal derate: one event in, one result out.
// Input channel: in_valid / in_stall with mode, percent_request, temperature and
//   readback_value; an item is taken when in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with level, write_request, shown_percent
//   and three ASCII digits; the result register holds until out_stall is low.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index 0..3 selects
//   full_scale, derate_start_temp, derate_end_temp, derate_floor_percent;
//   other indexes are ignored. Write only while no item is in flight.
// One item at a time; the next item can be taken in the cycle in which out_valid
//   rises. Readback, ignored set percent, cold sample and unused modes go
//   straight to the percent division; up/down steps and set percent first apply
//   the new level; derating samples first divide for the cap. The 29-step
//   restoring divider runs once per item for the percent, again for the cap.
// A new item is taken once the previous result is in the output register, even
//   while that result still waits on out_stall; if the receiver stalls, the
//   following item finishes and then waits until the output register frees.
// Reset (rst, synchronous) restores the register defaults and a level of 9830,
//   and clears the output valid.
// depends on blwd_pkg, blwd_ctrl, blwd_datapath
module backlight_level_with_thermal_derate (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [blwd_pkg::MODE_BITS-1:0]     mode,
  input  logic [blwd_pkg::PREQ_BITS-1:0]     percent_request,
  input  logic [blwd_pkg::TEMP_BITS-1:0]     temperature,
  input  logic [blwd_pkg::RB_BITS-1:0]       readback_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [blwd_pkg::LEVEL_BITS-1:0]    level,
  output logic                               write_request,
  output logic [blwd_pkg::PCT_BITS-1:0]      shown_percent,
  output logic [blwd_pkg::DIGIT_BITS-1:0]    digit_hundreds,
  output logic [blwd_pkg::DIGIT_BITS-1:0]    digit_tens,
  output logic [blwd_pkg::DIGIT_BITS-1:0]    digit_units,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [blwd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [blwd_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  blwd_pkg::dp_cmd_t    cmd;
  blwd_pkg::dp_status_t status;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  blwd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  blwd_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mode            (mode),
    .percent_request (percent_request),
    .temperature     (temperature),
    .readback_value  (readback_value),
    .level           (level),
    .write_request   (write_request),
    .shown_percent   (shown_percent),
    .digit_hundreds  (digit_hundreds),
    .digit_tens      (digit_tens),
    .digit_units     (digit_units)
  );

endmodule
